@@ hdl/qtue_pkg.sv @@
// Shared constants, types and helper functions of the Q table update engine.
package qtue_pkg;

    // Table shape (STATE_COUNT and ACTION_COUNT must be powers of two)
    localparam int STATE_COUNT  = 256;
    localparam int ACTION_COUNT = 8;
    localparam int ROW_W        = $clog2(STATE_COUNT);
    localparam int ACT_W        = $clog2(ACTION_COUNT);
    localparam int CNT_W        = $clog2(ACTION_COUNT + 1);

    // Field widths
    localparam int Q_W      = 32;
    localparam int RATE_W   = 17;
    localparam int DRAW_W   = 16;
    localparam int LOSS_W   = 31;
    localparam int AIU_W    = 4;
    localparam int CFG_W    = 17;
    localparam int CFG_IDX_W = 2;
    localparam int SAT_W    = 36;

    localparam logic [RATE_W-1:0] RATE_ONE = RATE_W'(65536);

    typedef logic signed [Q_W-1:0] t_q;
    typedef t_q [ACTION_COUNT-1:0] t_row;

    typedef struct packed {
        t_q               value;
        logic [ACT_W-1:0] index;
    } t_row_max;

    typedef enum logic {
        CMD_UPDATE = 1'b0,
        CMD_SELECT = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEARNING_RATE     = 2'd0,
        CFG_DISCOUNT          = 2'd1,
        CFG_EXPLOIT_THRESHOLD = 2'd2,
        CFG_ACTIONS_IN_USE    = 2'd3
    } t_cfg_index;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_DMUL,
        S_TGT,
        S_LMUL,
        S_OUT
    } t_state;

    // Limit a Q1.16 rate to one
    function automatic logic [RATE_W-1:0] rate_clip(input logic [RATE_W-1:0] r);
        return (r > RATE_ONE) ? RATE_ONE : r;
    endfunction

    // Actions taking part: zero acts as one, too many acts as all
    function automatic logic [CNT_W-1:0] used_count(input logic [AIU_W-1:0] n);
        logic [CNT_W-1:0] res;
        if (n == '0) begin
            res = CNT_W'(1);
        end else if (32'(n) > ACTION_COUNT) begin
            res = CNT_W'(ACTION_COUNT);
        end else begin
            res = CNT_W'(n);
        end
        return res;
    endfunction

    // Saturate a wide signed value to Q16.16
    function automatic t_q sat_q(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        t_q                      res;
        hi = SAT_W'(2147483647);
        lo = -hi - SAT_W'(1);
        if (v > hi) begin
            res = t_q'(hi);
        end else if (v < lo) begin
            res = t_q'(lo);
        end else begin
            res = t_q'(v);
        end
        return res;
    endfunction

endpackage

@@ hdl/qtue_row_max.sv @@
// Registered-free comparison tree giving the first largest value of a table row.
module qtue_row_max (
    input  qtue_pkg::t_row                   i_row,
    input  logic [qtue_pkg::CNT_W-1:0]       i_used,
    output qtue_pkg::t_row_max               o_max
);
    import qtue_pkg::*;

    t_q               node_val [1:2*ACTION_COUNT-1];
    logic             node_ok  [1:2*ACTION_COUNT-1];
    logic [ACT_W-1:0] node_idx [1:2*ACTION_COUNT-1];

    // Fill leaves, then reduce pairwise; right side wins only when strictly larger
    always_comb begin
        for (int i = 0; i < ACTION_COUNT; i++) begin
            node_val[ACTION_COUNT+i] = i_row[i];
            node_ok[ACTION_COUNT+i]  = (CNT_W'(i) < i_used);
            node_idx[ACTION_COUNT+i] = ACT_W'(i);
        end
        for (int k = ACTION_COUNT - 1; k >= 1; k--) begin
            if (node_ok[2*k+1] && (!node_ok[2*k] || (node_val[2*k+1] > node_val[2*k]))) begin
                node_val[k] = node_val[2*k+1];
                node_idx[k] = node_idx[2*k+1];
            end else begin
                node_val[k] = node_val[2*k];
                node_idx[k] = node_idx[2*k];
            end
            node_ok[k] = node_ok[2*k] || node_ok[2*k+1];
        end
    end

    assign o_max.value = node_val[1];
    assign o_max.index = node_idx[1];

endmodule

@@ hdl/q_table_update_engine_core.sv @@
// Top level of the Q table update engine: row memory, sequencer and fixed-point datapath.
//
//  Channel | Signals                                   | Direction | Handshake
//  --------+-------------------------------------------+-----------+----------------
//  request | i_command .. i_rand_action                | in        | i_valid/o_ready
//  result  | o_chosen_action .. o_step_loss            | out       | o_valid/i_ready
//  config  | i_cfg_index, i_cfg_data                   | in        | i_cfg_we
//
//  An update goes from acceptance through the row RAM read, then the discount multiply,
//  target add and learning-rate multiply, each owning a register stage, to the write-back;
//  a select goes from the row RAM read straight to the result step.
//  Reset is synchronous; per-row valid flip-flops make the whole table read as zero at
//  once, so there is no clearing pass. A result waiting in the output register stalls
//  only the last step; the next transaction is taken while it waits.
module q_table_update_engine_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request channel
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_command,
    input  logic [7:0]                        i_state_index,
    input  logic [2:0]                        i_action_index,
    input  logic signed [31:0]                i_reward,
    input  logic [7:0]                        i_next_state_index,
    input  logic [15:0]                       i_rand_draw,
    input  logic [2:0]                        i_rand_action,
    // result channel
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [2:0]                        o_chosen_action,
    output logic                              o_explored,
    output logic signed [31:0]                o_updated_value,
    output logic [30:0]                       o_step_loss,
    // configuration port
    input  logic                              i_cfg_we,
    input  logic [qtue_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [qtue_pkg::CFG_W-1:0]        i_cfg_data
);
    import qtue_pkg::*;

    // Configuration registers
    logic [RATE_W-1:0] r_learning_rate;
    logic [RATE_W-1:0] r_discount;
    logic [RATE_W-1:0] r_exploit_threshold;
    logic [AIU_W-1:0]  r_actions_in_use;

    // Sequencer and transaction registers
    t_state              r_state, n_state;
    t_cmd                r_cmd;
    logic [ROW_W-1:0]    r_state_row;
    logic [ROW_W-1:0]    r_next_row;
    logic [ACT_W-1:0]    r_action;
    t_q                  r_reward;
    logic [DRAW_W-1:0]   r_draw;

    // Datapath registers
    t_q                  r_max;
    logic [ACT_W-1:0]    r_idx;
    t_q                  r_old;
    logic signed [49:0]  r_dprod;
    logic signed [32:0]  r_diff;
    logic signed [50:0]  r_lprod;

    // Row memory and valid bits
    t_row                mem [STATE_COUNT];
    t_row                r_rd_a;
    t_row                r_rd_b;
    logic [STATE_COUNT-1:0] r_row_valid;

    // Result register
    logic                r_out_valid;
    logic [ACT_W-1:0]    r_out_action;
    logic                r_out_explored;
    t_q                  r_out_value;
    logic [LOSS_W-1:0]   r_out_loss;

    // Control strobes
    logic                accept;
    logic                out_free;
    logic                out_load;
    logic                mem_we;

    // Combinational datapath
    logic [CNT_W-1:0]    used;
    logic [ACT_W-1:0]    last_act;
    logic [RATE_W-1:0]   lr_c;
    logic [RATE_W-1:0]   disc_c;
    logic [RATE_W-1:0]   thr_c;
    logic signed [17:0]  lr_s;
    logic signed [17:0]  disc_s;
    t_row                row_a;
    t_row                row_b;
    t_row                tree_row;
    t_row_max            row_best;
    t_row                wr_row;
    logic [ACT_W-1:0]    in_action;
    logic signed [49:0]  dsum;
    logic signed [34:0]  tsum;
    t_q                  target;
    logic signed [51:0]  mix;
    t_q                  q_new;
    logic signed [32:0]  qdelta;
    logic [32:0]         qabs;
    logic [LOSS_W-1:0]   loss;
    logic                exploit;
    logic [ACT_W-1:0]    sel_action;

    // Clipped configuration
    assign used     = used_count(r_actions_in_use);
    assign last_act = ACT_W'(used - CNT_W'(1));
    assign lr_c     = rate_clip(r_learning_rate);
    assign disc_c   = rate_clip(r_discount);
    assign thr_c    = rate_clip(r_exploit_threshold);
    assign lr_s     = {1'b0, lr_c};
    assign disc_s   = {1'b0, disc_c};

    // Handshake strobes
    assign accept   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;

    // Sequencer: next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_FETCH;
            end
            S_FETCH: begin
                n_state = (r_cmd == CMD_SELECT) ? S_OUT : S_DMUL;
            end
            S_DMUL: n_state = S_TGT;
            S_TGT:  n_state = S_LMUL;
            S_LMUL: n_state = S_OUT;
            S_OUT: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer: outputs
    always_comb begin
        o_ready  = 1'b0;
        out_load = 1'b0;
        mem_we   = 1'b0;
        unique case (r_state)
            S_IDLE: o_ready = 1'b1;
            S_OUT: begin
                out_load = out_free;
                mem_we   = out_free && (r_cmd == CMD_UPDATE);
            end
            S_FETCH, S_DMUL, S_TGT, S_LMUL: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_learning_rate     <= RATE_W'(6554);
            r_discount          <= RATE_W'(58982);
            r_exploit_threshold <= RATE_W'(58982);
            r_actions_in_use    <= AIU_W'(8);
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_LEARNING_RATE:     r_learning_rate     <= i_cfg_data;
                CFG_DISCOUNT:          r_discount          <= i_cfg_data;
                CFG_EXPLOIT_THRESHOLD: r_exploit_threshold <= i_cfg_data;
                CFG_ACTIONS_IN_USE:    r_actions_in_use    <= i_cfg_data[AIU_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the action of interest to those in use
    always_comb begin
        in_action = (i_command == CMD_SELECT) ? i_rand_action : i_action_index;
        if (in_action > last_act) in_action = last_act;
    end

    // Capture the transaction
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd       <= t_cmd'(i_command);
            r_state_row <= i_state_index[ROW_W-1:0];
            r_next_row  <= i_next_state_index[ROW_W-1:0];
            r_action    <= in_action;
            r_reward    <= i_reward;
            r_draw      <= i_rand_draw;
        end
    end

    // Row memory: two registered reads on acceptance, one row write at the end
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[r_state_row] <= wr_row;
        if (accept) begin
            r_rd_a <= mem[i_state_index[ROW_W-1:0]];
            r_rd_b <= mem[i_next_state_index[ROW_W-1:0]];
        end
    end

    // Row valid bits: a row never written reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
        end else if (mem_we) begin
            r_row_valid[r_state_row] <= 1'b1;
        end
    end

    assign row_a    = r_row_valid[r_state_row] ? r_rd_a : '0;
    assign row_b    = r_row_valid[r_next_row]  ? r_rd_b : '0;
    assign tree_row = (r_cmd == CMD_SELECT) ? row_a : row_b;

    qtue_row_max u_row_max (
        .i_row  (tree_row),
        .i_used (used),
        .o_max  (row_best)
    );

    // Target: reward plus rounded discounted maximum, saturated (the old entry is subtracted in S_TGT)
    assign dsum   = r_dprod + 50'sd32768;
    assign tsum   = 35'(r_reward) + 35'($signed(dsum[49:16]));
    assign target = sat_q(SAT_W'(tsum));

    // New value: old + rate * (target - old), rounded and saturated
    assign mix    = 52'($signed({r_old, 16'b0})) + 52'(r_lprod) + 52'sd32768;
    assign q_new  = sat_q($signed(mix[51:16]));
    assign qdelta = 33'(q_new) - 33'(r_old);
    assign qabs   = qdelta[32] ? 33'(-qdelta) : 33'(qdelta);
    assign loss   = (qabs > 33'(31'h7FFF_FFFF)) ? '1 : qabs[LOSS_W-1:0];

    // Write-back row with the one entry replaced
    always_comb begin
        wr_row           = row_a;
        wr_row[r_action] = q_new;
    end

    // Select decision
    assign exploit    = (17'(r_draw) < thr_c);
    assign sel_action = exploit ? r_idx : r_action;

    // Datapath stages
    always_ff @(posedge i_clk) begin
        if (r_state == S_FETCH) begin
            r_max <= row_best.value;
            r_idx <= row_best.index;
            r_old <= row_a[r_action];
        end
        if (r_state == S_DMUL) r_dprod <= 50'(disc_s) * 50'(r_max);
        if (r_state == S_TGT)  r_diff  <= 33'(target) - 33'(r_old);
        if (r_state == S_LMUL) r_lprod <= 51'(lr_s) * 51'(r_diff);
    end

    // Result register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            if (r_cmd == CMD_SELECT) begin
                r_out_action   <= sel_action;
                r_out_explored <= !exploit;
                r_out_value    <= r_max;
                r_out_loss     <= '0;
            end else begin
                r_out_action   <= r_action;
                r_out_explored <= 1'b0;
                r_out_value    <= q_new;
                r_out_loss     <= loss;
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_chosen_action = r_out_action;
    assign o_explored      = r_out_explored;
    assign o_updated_value = r_out_value;
    assign o_step_loss     = r_out_loss;

    // Checks
    a_accept_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_FETCH))
        else $error("accepted transaction did not start a row fetch");

    a_write_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> ((r_state == S_OUT) && (r_cmd == CMD_UPDATE)))
        else $error("row write outside the update write-back step");

    a_row_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |=> r_row_valid[$past(r_state_row)])
        else $error("written row not marked valid");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (o_valid && (r_state == S_IDLE)))
        else $error("result load did not return the sequencer to idle");

    a_select_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_explored) |-> (o_step_loss == '0))
        else $error("explored select carries a non-zero loss");

endmodule

@@ dv/q_table_update_engine_core_tb.sv @@
// Self-checking testbench of the Q table update engine with its own table and arithmetic.
module q_table_update_engine_core_tb;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int REPORT_LIMIT   = 50;
    localparam int ENTRY_COUNT    = qtue_pkg::STATE_COUNT * qtue_pkg::ACTION_COUNT;
    localparam longint Q_MAX      = 64'sd2147483647;
    localparam longint Q_MIN      = -64'sd2147483648;
    localparam longint ONE_Q0_16  = 64'sd65536;

    typedef struct {
        qtue_pkg::t_cmd     cmd;
        logic [7:0]         row;
        logic [2:0]         act;
        logic signed [31:0] reward;
        logic [7:0]         next_row;
        logic [15:0]        draw;
        logic [2:0]         rnd_act;
    } t_request;

    typedef struct {
        logic [2:0]         act;
        logic               explored;
        logic signed [31:0] value;
        logic [30:0]        loss;
    } t_outcome;

    // DUT connections
    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_valid = 1'b0;
    logic                            o_ready;
    logic                            i_command = 1'b0;
    logic [7:0]                      i_state_index = '0;
    logic [2:0]                      i_action_index = '0;
    logic signed [31:0]              i_reward = '0;
    logic [7:0]                      i_next_state_index = '0;
    logic [15:0]                     i_rand_draw = '0;
    logic [2:0]                      i_rand_action = '0;
    logic                            o_valid;
    logic                            i_ready = 1'b0;
    logic [2:0]                      o_chosen_action;
    logic                            o_explored;
    logic signed [31:0]              o_updated_value;
    logic [30:0]                     o_step_loss;
    logic                            i_cfg_we = 1'b0;
    logic [qtue_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [qtue_pkg::CFG_W-1:0]      i_cfg_data = '0;

    // Predictor state: value table and register copies
    logic signed [31:0] q_mem [0:ENTRY_COUNT-1];
    logic [16:0]        cfg_rate = 17'd6554;
    logic [16:0]        cfg_disc = 17'd58982;
    logic [16:0]        cfg_thresh = 17'd58982;
    logic [3:0]         cfg_actions = 4'd8;

    t_request queued_requests[$];
    t_outcome awaited_outcomes[$];
    t_request cur_req;
    t_outcome want;
    logic     valid_next;
    logic     ready_next;
    int       tx_idle = 0;
    int       rx_idle = 0;
    int       idle_pct = 0;
    int       mismatch_count = 0;
    int       quiet_cycles = 0;
    logic [7:0] hot_rows [4] = '{8'h00, 8'h5A, 8'hA5, 8'hFF};

    q_table_update_engine_core i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_command          (i_command),
        .i_state_index      (i_state_index),
        .i_action_index     (i_action_index),
        .i_reward           (i_reward),
        .i_next_state_index (i_next_state_index),
        .i_rand_draw        (i_rand_draw),
        .i_rand_action      (i_rand_action),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_chosen_action    (o_chosen_action),
        .o_explored         (o_explored),
        .o_updated_value    (o_updated_value),
        .o_step_loss        (o_step_loss),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Round a Q32.32 quantity to Q16.16, halves towards plus infinity
    function automatic longint round_q16(input longint v);
        return (v + 64'sd32768) >>> 16;
    endfunction

    function automatic longint saturate_q(input longint v);
        if (v > Q_MAX) return Q_MAX;
        if (v < Q_MIN) return Q_MIN;
        return v;
    endfunction

    function automatic longint clip_rate(input logic [16:0] r);
        return (longint'(r) > ONE_Q0_16) ? ONE_Q0_16 : longint'(r);
    endfunction

    // First highest entry among the actions taking part
    function automatic void find_best(input logic [7:0] row, input int n_act,
                                      output int idx, output longint val);
        longint e;
        idx = 0;
        val = q_mem[{row, 3'd0}];
        for (int i = 1; i < n_act; i++) begin
            e = q_mem[{row, 3'(i)}];
            if (e > val) begin
                val = e;
                idx = i;
            end
        end
    endfunction

    // Work out the result of one request and apply it to the table copy
    function automatic t_outcome apply_q_request(input t_request rq);
        t_outcome oc;
        longint   lr, disc, target, old_v, mix, neu, diff, best_v;
        int       n_act, last, a, best_i;
        lr    = clip_rate(cfg_rate);
        disc  = clip_rate(cfg_disc);
        n_act = (cfg_actions == 4'd0) ? 1 :
                (int'(cfg_actions) > qtue_pkg::ACTION_COUNT) ? qtue_pkg::ACTION_COUNT :
                int'(cfg_actions);
        last  = n_act - 1;
        oc.explored = 1'b0;
        oc.loss     = '0;
        if (rq.cmd == qtue_pkg::CMD_UPDATE) begin
            a = (int'(rq.act) > last) ? last : int'(rq.act);
            find_best(rq.next_row, n_act, best_i, best_v);
            target = saturate_q(longint'(rq.reward) + round_q16(disc * best_v));
            old_v  = q_mem[{rq.row, 3'(a)}];
            mix    = (ONE_Q0_16 - lr) * old_v + lr * target;
            neu    = saturate_q(round_q16(mix));
            q_mem[{rq.row, 3'(a)}] = 32'(neu);
            diff = (neu > old_v) ? neu - old_v : old_v - neu;
            if (diff > Q_MAX) diff = Q_MAX;
            oc.act   = 3'(a);
            oc.value = 32'(neu);
            oc.loss  = 31'(diff);
        end else begin
            find_best(rq.row, n_act, best_i, best_v);
            oc.value = 32'(best_v);
            if (longint'(rq.draw) < clip_rate(cfg_thresh)) begin
                oc.act = 3'(best_i);
            end else begin
                oc.act      = (int'(rq.rnd_act) > last) ? 3'(last) : rq.rnd_act;
                oc.explored = 1'b1;
            end
        end
        return oc;
    endfunction

    function automatic t_request mk_update(input logic [7:0] row, input logic [2:0] act,
                                           input logic signed [31:0] reward,
                                           input logic [7:0] next_row);
        t_request rq;
        rq.cmd      = qtue_pkg::CMD_UPDATE;
        rq.row      = row;
        rq.act      = act;
        rq.reward   = reward;
        rq.next_row = next_row;
        rq.draw     = 16'($urandom);
        rq.rnd_act  = 3'($urandom);
        return rq;
    endfunction

    function automatic t_request mk_select(input logic [7:0] row, input logic [15:0] draw,
                                           input logic [2:0] rnd_act);
        t_request rq;
        rq.cmd      = qtue_pkg::CMD_SELECT;
        rq.row      = row;
        rq.act      = 3'($urandom);
        rq.reward   = 32'($urandom);
        rq.next_row = 8'($urandom);
        rq.draw     = draw;
        rq.rnd_act  = rnd_act;
        return rq;
    endfunction

    // Mostly hot rows so values build up, the rest anywhere in the table
    function automatic logic [7:0] pick_row();
        if ($urandom_range(0, 99) < 70) return hot_rows[$urandom_range(0, 3)];
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic t_request random_request();
        logic signed [31:0] r;
        logic [15:0]        d;
        longint             t;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: r = 32'(int'($urandom_range(0, 1048576)) - 524288);
            4, 5, 6:    r = 32'($urandom);
            7: begin
                case ($urandom_range(0, 4))
                    0:       r = 32'sh7FFFFFFF;
                    1:       r = 32'sh80000000;
                    2:       r = 32'sd0;
                    3:       r = -32'sd1;
                    default: r = 32'sd1;
                endcase
            end
            default:    r = 32'(int'($urandom_range(0, 67108864)) - 33554432);
        endcase
        t = clip_rate(cfg_thresh);
        case ($urandom_range(0, 9))
            7:       d = 16'((t == 0) ? 0 : t - 1);
            8:       d = 16'((t > 65535) ? 65535 : t);
            9:       d = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: d = 16'($urandom);
        endcase
        if ($urandom_range(0, 99) < 55) return mk_update(pick_row(), 3'($urandom), r, pick_row());
        return mk_select(pick_row(), d, 3'($urandom));
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < REPORT_LIMIT) $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Write one register and keep the predictor copy in step
    task automatic write_reg(input qtue_pkg::t_cfg_index idx, input logic [16:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            qtue_pkg::CFG_LEARNING_RATE:     cfg_rate = data;
            qtue_pkg::CFG_DISCOUNT:          cfg_disc = data;
            qtue_pkg::CFG_EXPLOIT_THRESHOLD: cfg_thresh = data;
            qtue_pkg::CFG_ACTIONS_IN_USE:    cfg_actions = data[3:0];
            default: ;
        endcase
    endtask

    task automatic program_engine(input logic [16:0] lr, input logic [16:0] disc,
                                  input logic [16:0] thr, input logic [16:0] n_act);
        write_reg(qtue_pkg::CFG_LEARNING_RATE, lr);
        write_reg(qtue_pkg::CFG_DISCOUNT, disc);
        write_reg(qtue_pkg::CFG_EXPLOIT_THRESHOLD, thr);
        write_reg(qtue_pkg::CFG_ACTIONS_IN_USE, n_act);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Hold until every request is taken and every result is back, then let the pipe settle
    task automatic wait_engine_idle();
        do @(negedge i_clk);
        while (queued_requests.size() != 0 || i_valid || awaited_outcomes.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_random(input int count, input int pct);
        idle_pct = pct;
        repeat (count) queued_requests.push_back(random_request());
        wait_engine_idle();
    endtask

    // Request driver: present queued transactions with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            tx_idle = 0;
        end else begin
            if (i_valid && o_ready) begin
                awaited_outcomes.push_back(apply_q_request(cur_req));
            end
            if (!i_valid || o_ready) begin
                if (tx_idle > 0) begin
                    tx_idle--;
                    valid_next = 1'b0;
                end else if (queued_requests.size() == 0) begin
                    valid_next = 1'b0;
                end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                    tx_idle    = $urandom_range(0, 4);
                    valid_next = 1'b0;
                end else begin
                    cur_req    = queued_requests.pop_front();
                    valid_next = 1'b1;
                end
                i_valid <= valid_next;
                if (valid_next) begin
                    i_command          <= cur_req.cmd;
                    i_state_index      <= cur_req.row;
                    i_action_index     <= cur_req.act;
                    i_reward           <= cur_req.reward;
                    i_next_state_index <= cur_req.next_row;
                    i_rand_draw        <= cur_req.draw;
                    i_rand_action      <= cur_req.rnd_act;
                end
            end
        end
    end

    // Result monitor: check each transaction against the oldest prediction, stall at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            rx_idle = 0;
        end else begin
            if (o_valid && i_ready) begin
                if (awaited_outcomes.size() == 0) begin
                    report_mismatch($sformatf("result with nothing expected, value %0d",
                                              o_updated_value));
                end else begin
                    want = awaited_outcomes.pop_front();
                    if (o_chosen_action !== want.act)
                        report_mismatch($sformatf("chosen_action %0d, expected %0d",
                                                  o_chosen_action, want.act));
                    if (o_explored !== want.explored)
                        report_mismatch($sformatf("explored %0b, expected %0b",
                                                  o_explored, want.explored));
                    if (o_updated_value !== want.value)
                        report_mismatch($sformatf("updated_value %0d, expected %0d",
                                                  o_updated_value, want.value));
                    if (o_step_loss !== want.loss)
                        report_mismatch($sformatf("step_loss %0d, expected %0d",
                                                  o_step_loss, want.loss));
                end
            end
            if (rx_idle > 0) begin
                rx_idle--;
                ready_next = 1'b0;
            end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                rx_idle    = $urandom_range(0, 4);
                ready_next = 1'b0;
            end else begin
                ready_next = 1'b1;
            end
            i_ready <= ready_next;
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        for (int i = 0; i < ENTRY_COUNT; i++) q_mem[i] = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle_pct = 30;

        // Reset settings: empty rows, extreme rewards and draws either side of the threshold
        queued_requests.push_back(mk_select(8'd0, 16'd0, 3'd0));
        queued_requests.push_back(mk_select(8'd255, 16'hFFFF, 3'd7));
        queued_requests.push_back(mk_update(8'd255, 3'd7, 32'sh7FFFFFFF, 8'd255));
        queued_requests.push_back(mk_update(8'd0, 3'd0, 32'sh80000000, 8'd0));
        queued_requests.push_back(mk_update(8'd255, 3'd0, 32'sh80000000, 8'd0));
        queued_requests.push_back(mk_select(8'd255, 16'd0, 3'd2));
        queued_requests.push_back(mk_select(8'd0, 16'd58981, 3'd3));
        queued_requests.push_back(mk_select(8'd0, 16'd58982, 3'd3));
        queued_requests.push_back(mk_update(8'd128, 3'd3, 32'sd0, 8'd255));
        queued_requests.push_back(mk_update(8'd127, 3'd4, -32'sd1, 8'd0));
        wait_engine_idle();

        // Full rate, no discount, few actions: saturated change, clamped action, ties
        program_engine(17'd65536, 17'd0, 17'd65536, 17'd3);
        queued_requests.push_back(mk_update(8'd5, 3'd0, 32'sh80000000, 8'd0));
        queued_requests.push_back(mk_update(8'd5, 3'd0, 32'sh7FFFFFFF, 8'd0));
        queued_requests.push_back(mk_update(8'd5, 3'd7, 32'sh00050000, 8'd0));
        queued_requests.push_back(mk_update(8'd5, 3'd1, 32'sh7FFFFFFF, 8'd0));
        queued_requests.push_back(mk_select(8'd5, 16'hFFFF, 3'd6));
        queued_requests.push_back(mk_select(8'd6, 16'd0, 3'd1));
        wait_engine_idle();

        // Full discount, threshold zero: target overflow and forced exploration
        program_engine(17'd65536, 17'd65536, 17'd0, 17'd8);
        queued_requests.push_back(mk_update(8'd9, 3'd1, 32'sh7FFFFFFF, 8'd5));
        queued_requests.push_back(mk_update(8'd9, 3'd2, 32'sh80000000, 8'd0));
        queued_requests.push_back(mk_select(8'd9, 16'd0, 3'd7));
        queued_requests.push_back(mk_update(8'd10, 3'd6, 32'sh00018000, 8'd10));
        wait_engine_idle();

        // Random phases over fixed corner settings
        program_engine(17'd6554, 17'd58982, 17'd58982, 17'd8);
        run_random(150, 30);
        program_engine(17'd65536, 17'd65536, 17'd32768, 17'd4);
        run_random(100, 30);
        program_engine(17'd0, 17'd65536, 17'd0, 17'd8);
        run_random(80, 20);
        program_engine(17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'd0);
        run_random(100, 40);
        program_engine(17'd32768, 17'd0, 17'd65535, 17'd15);
        run_random(100, 0);
        program_engine(17'd1, 17'd65535, 17'd16384, 17'd1);
        run_random(80, 30);
        program_engine(17'd65536, 17'd65536, 17'd65536, 17'd9);
        run_random(100, 30);

        // Random settings, now and then with stray high bits in the action count
        repeat (4) begin
            program_engine(17'($urandom_range(0, 131071)), 17'($urandom_range(0, 70000)),
                           17'($urandom_range(0, 70000)),
                           ($urandom_range(0, 3) == 0) ? 17'($urandom)
                                                       : 17'($urandom_range(1, 8)));
            run_random(100, $urandom_range(10, 40));
        end

        // Closing stretch without idling
        program_engine(17'd6554, 17'd58982, 17'd58982, 17'd8);
        run_random(150, 0);

        if (mismatch_count == 0 && awaited_outcomes.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
